// File: src/crc32_posix_block_fold_defines.svh
// Assertion helpers for the CRC block checker
`ifndef CRC32_POSIX_BLOCK_FOLD_DEFINES_SVH
`define CRC32_POSIX_BLOCK_FOLD_DEFINES_SVH

// checked only outside reset
`define CRCPBF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("crcpbf check failed");

// checked on every edge, reset included
`define CRCPBF_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("crcpbf check failed");

`endif

// File: src/crcpbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package crcpbf_pkg;

    localparam int LANES = 16;
    localparam int CNT_W = 5;
    localparam logic [31:0] CRC_POLY = 32'h04C11DB7;

    typedef logic [LANES-1:0][7:0][31:0] lane_tab_t;
    typedef logic [LANES:0][31:0][31:0]  shift_tab_t;

    typedef struct packed {
        logic             valid;
        logic             start;
        logic [CNT_W-1:0] nbytes;
    } stage_ctrl_t;

    function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h0};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // column b of lane k: contribution of bit b of the byte at position k,
    // followed by the remaining bytes of a 16-byte word
    function automatic lane_tab_t build_lane_tab();
        lane_tab_t   t;
        logic [31:0] c;
        logic [7:0]  b;
        for (int k = 0; k < LANES; k++) begin
            for (int bit_i = 0; bit_i < 8; bit_i++) begin
                c = 32'h0;
                for (int p = 0; p < LANES; p++) begin
                    b = (p == k) ? 8'(1 << bit_i) : 8'h0;
                    c = fold_byte(c, b);
                end
                t[k][bit_i] = c;
            end
        end
        return t;
    endfunction

    // column i for n: register bit i advanced over n zero bytes
    function automatic shift_tab_t build_shift_tab();
        shift_tab_t  t;
        logic [31:0] c;
        for (int n = 0; n <= LANES; n++) begin
            for (int i = 0; i < 32; i++) begin
                c = 32'(1) << i;
                for (int p = 0; p < n; p++) begin
                    c = fold_byte(c, 8'h0);
                end
                t[n][i] = c;
            end
        end
        return t;
    endfunction

    localparam lane_tab_t  LANE_TAB  = build_lane_tab();
    localparam shift_tab_t SHIFT_TAB = build_shift_tab();

endpackage
`default_nettype wire

// File: src/crcpbf_lanes.sv
`timescale 1ns / 1ps
`default_nettype none
module crcpbf_lanes
    import crcpbf_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       advance,
    input  wire stage_ctrl_t                ctrl_in,
    input  wire logic [8*LANES-1:0]         aligned,
    output stage_ctrl_t                     ctrl_reg,
    output logic [LANES-1:0][31:0]          lane_reg
);

    logic [LANES-1:0][31:0] lane_next;

    // one byte lane per position; leading zero bytes leave a zero-init CRC untouched
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        always_comb begin
            logic [7:0]  b;
            logic [31:0] acc;
            b   = aligned[8*(LANES-k)-1 -: 8];
            acc = 32'h0;
            for (int i = 0; i < 8; i++) begin
                if (b[i]) begin
                    acc = acc ^ LANE_TAB[k][i];
                end
            end
            lane_next[k] = acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (advance) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            lane_reg <= lane_next;
        end
    end

endmodule
`default_nettype wire

// File: src/crcpbf_merge.sv
`timescale 1ns / 1ps
`default_nettype none
module crcpbf_merge
    import crcpbf_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   advance,
    input  wire stage_ctrl_t            ctrl_in,
    input  wire logic [LANES-1:0][31:0] lane_in,
    output logic                        out_valid_reg,
    output logic [31:0]                 out_crc_reg,
    output logic [63:0]                 out_len_reg,
    output logic                        out_ovf_reg
);

    logic [31:0] crc_reg, crc_next;
    logic [63:0] length_reg, length_next;
    logic        overflow_reg, overflow_next;

    always_comb begin
        logic [31:0] base;
        logic [31:0] acc;
        logic [63:0] len_base;
        logic [64:0] sum;
        base     = ctrl_in.start ? 32'h0 : crc_reg;
        len_base = ctrl_in.start ? 64'h0 : length_reg;
        acc      = 32'h0;
        for (int i = 0; i < 32; i++) begin
            if (base[i]) begin
                acc = acc ^ SHIFT_TAB[ctrl_in.nbytes][i];
            end
        end
        for (int k = 0; k < LANES; k++) begin
            acc = acc ^ lane_in[k];
        end
        sum           = {1'b0, len_base} + {{(65-CNT_W){1'b0}}, ctrl_in.nbytes};
        crc_next      = acc;
        length_next   = sum[63:0];
        overflow_next = (overflow_reg & ~ctrl_in.start) | sum[64];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= '0;
            length_reg    <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= ctrl_in.valid;
            if (ctrl_in.valid) begin
                crc_reg      <= crc_next;
                length_reg   <= length_next;
                overflow_reg <= overflow_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && ctrl_in.valid) begin
            out_crc_reg <= crc_next;
            out_len_reg <= length_next;
            out_ovf_reg <= overflow_next;
        end
    end

endmodule
`default_nettype wire

// File: src/crc32_posix_block_fold.sv
// Running CRC-32 (poly 04C11DB7, MSB first, init 0, no final xor) over a
// byte stream that arrives up to 16 bytes per request, plus a 64-bit byte
// count with a sticky wrap flag.
// Input: s_axis_*; tdata carries two 64-bit words and a byte count, first
// stream byte in the top byte of data_hi. Only the leading byte_count bytes
// count (above 16 reads as 16, zero folds nothing). tuser = start_req
// clears crc, count and flag before the request.
// Output: m_axis_*; one result per request with the running values.
// Stages: capture, byte lanes, merge, each registered. Throughput: one
// request per cycle unless m_axis_tready stalls the output; the crc feedback
// is a single 32x32 xor matrix per byte count in the merge stage.
// Back-pressure: all stages move together; with m_axis_tready low and a
// result waiting, s_axis_tready drops and everything holds.
// Reset: synchronous, active low; empties the pipe and clears the state.
`timescale 1ns / 1ps
`default_nettype none
module crc32_posix_block_fold
    import crcpbf_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [135:0] s_axis_tdata,  // data_hi, data_lo, byte_count, zero pad
    input  wire logic         s_axis_tuser,  // start_req
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [95:0]       m_axis_tdata,  // crc_value, total_bytes
    output logic              m_axis_tuser   // count_overflow
);

    logic                   advance;
    logic [CNT_W-1:0]       n_sat;
    logic [CNT_W-1:0]       pad_bytes;
    stage_ctrl_t            in_ctrl_reg;
    logic [8*LANES-1:0]     aligned_reg;
    stage_ctrl_t            lane_ctrl;
    logic [LANES-1:0][31:0] lane_val;
    logic                   out_valid;
    logic [31:0]            out_crc;
    logic [63:0]            out_len;
    logic                   out_ovf;

    assign advance   = !out_valid || m_axis_tready;
    assign n_sat     = (s_axis_tdata[132:128] > CNT_W'(LANES)) ? CNT_W'(LANES)
                                                               : s_axis_tdata[132:128];
    assign pad_bytes = CNT_W'(LANES) - n_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ctrl_reg <= '0;
        end else if (advance) begin
            in_ctrl_reg.valid  <= s_axis_tvalid;
            in_ctrl_reg.start  <= s_axis_tuser;
            in_ctrl_reg.nbytes <= n_sat;
        end
    end

    // right-align the valid bytes; zeros shift in ahead of them
    always_ff @(posedge aclk) begin
        if (advance) begin
            aligned_reg <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} >> {pad_bytes, 3'b000};
        end
    end

    crcpbf_lanes u_lanes (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .ctrl_in  (in_ctrl_reg),
        .aligned  (aligned_reg),
        .ctrl_reg (lane_ctrl),
        .lane_reg (lane_val)
    );

    crcpbf_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .ctrl_in       (lane_ctrl),
        .lane_in       (lane_val),
        .out_valid_reg (out_valid),
        .out_crc_reg   (out_crc),
        .out_len_reg   (out_len),
        .out_ovf_reg   (out_ovf)
    );

    assign s_axis_tready = advance;
    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {out_len, out_crc};
    assign m_axis_tuser  = out_ovf;

endmodule
`default_nettype wire

// File: src/crcpbf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "crc32_posix_block_fold_defines.svh"
module crcpbf_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [95:0]  m_axis_tdata,
    input wire logic         m_axis_tuser
);

    // reset leaves no result pending
    `CRCPBF_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_axis_tvalid)

    // a stalled result holds its payload
    `CRCPBF_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // input side stalls only behind a waiting result
    `CRCPBF_ASSERT(a_ready_link, s_axis_tready == (!m_axis_tvalid || m_axis_tready))

    // a request taken while the output drains keeps the pipe moving
    `CRCPBF_ASSERT(a_accept_moves, s_axis_tvalid && s_axis_tready && m_axis_tvalid |->
        m_axis_tready)

endmodule

bind crc32_posix_block_fold crcpbf_checker u_crcpbf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
